>>> sv/ctd_pkg.sv
// Types, codes and sizes shared by the task dispatcher modules.
// Depends on nothing.
package ctd_pkg;

	localparam int NUM_TASKS   = 8;
	localparam int QUEUE_DEPTH = 16;

	typedef enum logic [2:0] {
		OP_CREATE   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_DISPATCH = 3'd2,
		OP_YIELD    = 3'd3,
		OP_TERM     = 3'd4,
		OP_BLOCK    = 3'd5,
		OP_SUSPEND  = 3'd6,
		OP_RESUME   = 3'd7
	} opcode_t;

	typedef enum logic [2:0] {
		TK_FREE  = 3'd0,
		TK_READY = 3'd1,
		TK_RUN   = 3'd2,
		TK_BLOCK = 3'd3,
		TK_STOP  = 3'd4
	} tstate_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_POP,
		S_POP_CHK,
		S_POP_ST,
		S_PURGE,
		S_FETCH,
		S_RESULT
	} seq_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [2:0] task_id;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  running_task;
		logic        run_valid;
		logic [2:0]  addressed_state;
		logic [4:0]  queued_entries;
		logic [3:0]  live_tasks;
		logic [31:0] tick_total;
		logic        queue_overflow;
		logic        bad_request;
	} res_t;

endpackage

>>> sv/ctd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module ctd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> sv/ctd_qaddr.sv
// Ring address adder for the ready queue: base plus offset, wrapped at DEPTH.
// Depends on nothing; offset is at most DEPTH.
module ctd_qaddr #(
	parameter int DEPTH = 16
) (
	input  logic [$clog2(DEPTH)-1:0]   base,
	input  logic [$clog2(DEPTH+1)-1:0] offset,
	output logic [$clog2(DEPTH)-1:0]   addr
);

	localparam int AW = $clog2(DEPTH);
	localparam int SW = $clog2(DEPTH + 1) + 1;

	logic [SW-1:0] sum;
	logic [SW-1:0] wrapped;

	always_comb begin
		sum = SW'(base) + SW'(offset);
		if (sum >= SW'(DEPTH)) begin
			wrapped = sum - SW'(DEPTH);
		end else begin
			wrapped = sum;
		end
		addr = AW'(wrapped);
	end

endmodule

>>> sv/cooperative_task_dispatcher_core.sv
// Top level of the cooperative task dispatcher: sequencer, task state RAM, ready queue.
// Depends on ctd_pkg, ctd_ram and ctd_qaddr.
//
//   channel  | signals             | handshake
//   ---------+---------------------+------------------------------------
//   command  | cmd (cmd_t)         | taken when start is high, busy low
//   result   | result (res_t)      | done high for one cycle, no stall
//
// Create, yield, terminate, block, suspend and resume go from idle through the execute, fetch and result states.
// Dispatch pops queue entries, each through the pop, check and state steps, until it finds a
// ready task or the queue runs dry; dispatch with a task running pops nothing.
// Delete compacts the queue one entry a cycle.
// Each RAM has one read port; results are never stalled.
// Reset clears all task states at once through per-task valid bits.
module cooperative_task_dispatcher_core import ctd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  cmd_t cmd,
	output logic done,
	output res_t result
);

	localparam int TID_W  = $clog2(NUM_TASKS);
	localparam int QA_W   = $clog2(QUEUE_DEPTH);
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CNT_W  = $clog2(NUM_TASKS + 1);

	seq_t state_q, state_d;

	opcode_t            op_q;
	logic [2:0]         id_q;
	logic               idok_q;
	logic [TID_W-1:0]   tid;
	logic [TID_W-1:0]   cur_q;
	logic               curv_q;
	logic [QA_W-1:0]    head_q;
	logic [QA_W-1:0]    rp_q;
	logic [FILL_W-1:0]  fill_q;
	logic [FILL_W-1:0]  rd_q;
	logic [FILL_W-1:0]  wn_q;
	logic               pend_q;
	logic [CNT_W-1:0]   total_q;
	logic [31:0]        tick_q;
	logic               ovf_q;
	logic               bad_q;
	logic [NUM_TASKS-1:0] stv_q;

	logic               st_we, st_re;
	logic [TID_W-1:0]   st_waddr, st_raddr;
	logic [2:0]         st_wdata, st_rdata;
	logic               q_we, q_re;
	logic [QA_W-1:0]    q_waddr, q_raddr;
	logic [TID_W-1:0]   q_wdata, q_rdata;
	logic [FILL_W-1:0]  qa_off;
	logic [QA_W-1:0]    qa_addr;

	logic               accept;
	tstate_t            cur_st;
	logic               act;
	logic               push_req;
	logic               push_ok;
	logic               pop_ready;
	logic               purge_keep;
	logic               purge_rd;
	logic [QA_W-1:0]    head_inc;
	logic [QA_W-1:0]    rp_inc;

	ctd_ram #(.WIDTH(3), .DEPTH(NUM_TASKS)) u_st_ram (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	ctd_ram #(.WIDTH(TID_W), .DEPTH(QUEUE_DEPTH)) u_q_ram (
		.clk   (clk),
		.we    (q_we),
		.waddr (q_waddr),
		.wdata (q_wdata),
		.re    (q_re),
		.raddr (q_raddr),
		.rdata (q_rdata)
	);

	ctd_qaddr #(.DEPTH(QUEUE_DEPTH)) u_qaddr (
		.base   (head_q),
		.offset (qa_off),
		.addr   (qa_addr)
	);

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign tid    = TID_W'(id_q);

	assign head_inc = (head_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;
	assign rp_inc   = (rp_q == QA_W'(QUEUE_DEPTH - 1)) ? '0 : rp_q + 1'b1;

	always_comb begin
		cur_st = TK_FREE;
		if (idok_q && stv_q[tid]) begin
			cur_st = tstate_t'(st_rdata);
		end
		unique case (op_q)
			OP_CREATE:   act = idok_q && (cur_st == TK_FREE);
			OP_DELETE:   act = idok_q && (cur_st != TK_FREE);
			OP_DISPATCH: act = !curv_q;
			OP_YIELD:    act = curv_q;
			OP_TERM:     act = curv_q;
			OP_BLOCK:    act = curv_q;
			OP_SUSPEND:  act = idok_q && (cur_st == TK_READY || cur_st == TK_RUN);
			OP_RESUME:   act = idok_q && (cur_st == TK_BLOCK);
			default:     act = 1'b0;
		endcase
		push_req = (state_q == S_EXEC) && act
			&& (op_q == OP_CREATE || op_q == OP_YIELD || op_q == OP_RESUME);
		push_ok    = push_req && (fill_q < FILL_W'(QUEUE_DEPTH));
		pop_ready  = stv_q[q_rdata] && (tstate_t'(st_rdata) == TK_READY);
		purge_rd   = (rd_q < fill_q);
		purge_keep = pend_q && (q_rdata != tid);
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:    if (start) state_d = S_EXEC;
			S_EXEC: begin
				if (op_q == OP_DELETE && act) begin
					state_d = S_PURGE;
				end else if (op_q == OP_DISPATCH && act) begin
					state_d = S_POP;
				end else begin
					state_d = S_FETCH;
				end
			end
			S_POP:     state_d = (fill_q == '0) ? S_FETCH : S_POP_CHK;
			S_POP_CHK: state_d = S_POP_ST;
			S_POP_ST:  state_d = pop_ready ? S_FETCH : S_POP;
			S_PURGE:   if (!purge_rd && !pend_q) state_d = S_FETCH;
			S_FETCH:   state_d = S_RESULT;
			S_RESULT:  state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	// RAM controls and result
	always_comb begin
		st_we    = 1'b0;
		st_waddr = tid;
		st_wdata = TK_FREE;
		st_re    = 1'b0;
		st_raddr = tid;
		q_we     = 1'b0;
		q_waddr  = qa_addr;
		q_wdata  = tid;
		q_re     = 1'b0;
		q_raddr  = head_q;
		qa_off   = fill_q;
		done     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				st_re    = start;
				st_raddr = TID_W'(cmd.task_id);
			end
			S_EXEC: begin
				q_we = push_ok;
				if (op_q == OP_YIELD) q_wdata = cur_q;
				if (act) begin
					unique case (op_q)
						OP_CREATE:   begin st_we = 1'b1; st_wdata = TK_READY; end
						OP_DELETE:   begin st_we = 1'b1; st_wdata = TK_FREE;  end
						OP_DISPATCH: st_we = 1'b0;
						OP_YIELD:    begin st_we = 1'b1; st_waddr = cur_q; st_wdata = TK_READY; end
						OP_TERM:     begin st_we = 1'b1; st_waddr = cur_q; st_wdata = TK_STOP;  end
						OP_BLOCK:    begin st_we = 1'b1; st_waddr = cur_q; st_wdata = TK_BLOCK; end
						OP_SUSPEND:  begin st_we = 1'b1; st_wdata = TK_BLOCK; end
						OP_RESUME:   begin st_we = 1'b1; st_wdata = TK_READY; end
						default:     st_we = 1'b0;
					endcase
				end
			end
			S_POP: begin
				q_re = (fill_q != '0);
			end
			S_POP_CHK: begin
				st_re    = 1'b1;
				st_raddr = q_rdata;
			end
			S_POP_ST: begin
				st_we    = pop_ready;
				st_waddr = q_rdata;
				st_wdata = TK_RUN;
			end
			S_PURGE: begin
				q_re    = purge_rd;
				q_raddr = rp_q;
				qa_off  = wn_q;
				q_we    = purge_keep;
				q_wdata = q_rdata;
			end
			S_FETCH: begin
				st_re = 1'b1;
			end
			S_RESULT: begin
				done = 1'b1;
			end
			default: begin
				done = 1'b0;
			end
		endcase

		result.running_task    = 3'(cur_q);
		result.run_valid       = curv_q;
		result.addressed_state = (idok_q && stv_q[tid]) ? st_rdata : TK_FREE;
		result.queued_entries  = 5'(fill_q);
		result.live_tasks      = 4'(total_q);
		result.tick_total      = tick_q;
		result.queue_overflow  = ovf_q;
		result.bad_request     = bad_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_q   <= '0;
			curv_q  <= 1'b0;
			head_q  <= '0;
			rp_q    <= '0;
			fill_q  <= '0;
			rd_q    <= '0;
			wn_q    <= '0;
			pend_q  <= 1'b0;
			total_q <= '0;
			tick_q  <= '0;
			ovf_q   <= 1'b0;
			bad_q   <= 1'b0;
			stv_q   <= '0;
		end else begin
			state_q <= state_d;
			if (st_we) stv_q[st_waddr] <= 1'b1;
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						ovf_q <= 1'b0;
						bad_q <= 1'b0;
					end
				end
				S_EXEC: begin
					if (push_ok) fill_q <= fill_q + 1'b1;
					if (push_req && !push_ok) ovf_q <= 1'b1;
					if (op_q == OP_DISPATCH) tick_q <= tick_q + 32'd1;
					if (op_q == OP_CREATE && idok_q && !act) bad_q <= 1'b1;
					if (act) begin
						unique case (op_q)
							OP_CREATE: total_q <= total_q + 1'b1;
							OP_DELETE: begin
								if (total_q != '0) total_q <= total_q - 1'b1;
								if (cur_q == tid) curv_q <= 1'b0;
								rp_q   <= head_q;
								rd_q   <= '0;
								wn_q   <= '0;
								pend_q <= 1'b0;
							end
							OP_DISPATCH: curv_q <= curv_q;
							OP_YIELD:    curv_q <= 1'b0;
							OP_TERM:     curv_q <= 1'b0;
							OP_BLOCK:    curv_q <= 1'b0;
							OP_SUSPEND: begin
								if (cur_st == TK_RUN && cur_q == tid) curv_q <= 1'b0;
							end
							OP_RESUME:   curv_q <= curv_q;
							default:     curv_q <= curv_q;
						endcase
					end
				end
				S_POP: begin
					if (fill_q != '0) begin
						head_q <= head_inc;
						fill_q <= fill_q - 1'b1;
					end
				end
				S_POP_ST: begin
					if (pop_ready) begin
						cur_q  <= q_rdata;
						curv_q <= 1'b1;
					end
				end
				S_PURGE: begin
					pend_q <= purge_rd;
					if (purge_rd) begin
						rp_q <= rp_inc;
						rd_q <= rd_q + 1'b1;
					end
					if (purge_keep) wn_q <= wn_q + 1'b1;
					if (!purge_rd && !pend_q) fill_q <= wn_q;
				end
				default: begin
					pend_q <= pend_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q   <= opcode_t'(cmd.operation);
			id_q   <= cmd.task_id;
			idok_q <= (32'(cmd.task_id) < NUM_TASKS);
		end
	end

`ifndef SYNTHESIS
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy && !done)
		else $error("accepted item did not make the block busy");

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(QUEUE_DEPTH))
		else $error("ready queue fill above depth");

	a_purge_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PURGE) |-> (wn_q <= rd_q))
		else $error("queue compaction write ran ahead of read");
`endif

endmodule
